[sv/apru_pkg.sv]
// shared types and constants for the aging page replacement unit
`timescale 1ns / 1ps

package apru_pkg;

  // fixed field widths
  localparam int PAGE_W  = 16;
  localparam int CFG_W   = 5;
  localparam int COUNT_W = 32;

  // defaults for the top-level parameters
  localparam int DEF_MAX_FRAMES = 16;
  localparam int DEF_AGE_BITS   = 16;

  // frame count after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd10;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_UPDATE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic walk;
    logic update;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic walk_last;
  } status_t;

endpackage

[sv/apru_ctrl.sv]
// controller state machine: idle, frame walk, table update
`timescale 1ns / 1ps

module apru_ctrl import apru_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.walk_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // commands and busy flag
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[sv/apru_dp.sv]
// datapath: frame table memory, walk search registers, counters and result word
`timescale 1ns / 1ps

module apru_dp import apru_pkg::*; #(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int AGE_BITS   = DEF_AGE_BITS,
  localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_active_frames,
  output logic               out_valid,
  output logic               out_hit,
  output logic [IDX_W-1:0]   out_frame_index,
  output logic               out_evicted_valid,
  output logic [PAGE_W-1:0]  out_evicted_page,
  output logic [COUNT_W-1:0] out_hits_so_far,
  output logic [COUNT_W-1:0] out_misses_so_far
);

  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int ENTRY_W = PAGE_W + AGE_BITS;
  localparam logic [AGE_BITS-1:0] AGE_TOP = AGE_BITS'(1) << (AGE_BITS - 1);

  // frame table: page number above age, one entry per frame
  logic [ENTRY_W-1:0]  frame_mem_r [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid_r;

  logic [CFG_W-1:0]    active_frames_r;
  logic [PAGE_W-1:0]   page_r;
  logic [CNT_W-1:0]    n_r;
  logic [CNT_W-1:0]    cnt_r;

  logic [PAGE_W-1:0]   rd_page_r;
  logic [AGE_BITS-1:0] rd_age_r;
  logic                rd_valid_r;

  logic                match_found_r;
  logic                empty_found_r;
  logic [IDX_W-1:0]    match_idx_r;
  logic [IDX_W-1:0]    empty_idx_r;
  logic [IDX_W-1:0]    old_idx_r;
  logic [AGE_BITS-1:0] match_age_r;
  logic [AGE_BITS-1:0] min_age_r;
  logic [PAGE_W-1:0]   old_page_r;

  logic [COUNT_W-1:0]  hit_total_r;
  logic [COUNT_W-1:0]  miss_total_r;
  logic [COUNT_W-1:0]  hit_total_nxt;
  logic [COUNT_W-1:0]  miss_total_nxt;

  logic                out_valid_r;
  logic                out_hit_r;
  logic [IDX_W-1:0]    out_frame_index_r;
  logic                out_evicted_valid_r;
  logic [PAGE_W-1:0]   out_evicted_page_r;
  logic [COUNT_W-1:0]  out_hits_r;
  logic [COUNT_W-1:0]  out_misses_r;

  logic [CNT_W-1:0]    n_clamp;
  logic                rd_en;
  logic                proc_en;
  logic [IDX_W-1:0]    proc_idx;
  logic [AGE_BITS-1:0] aged;
  logic                evict_now;
  logic [IDX_W-1:0]    slot;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]  wr_data;

  // frame count clamped to 1..MAX_FRAMES
  always_comb begin
    if (active_frames_r == '0) begin
      n_clamp = CNT_W'(1);
    end else if (32'(active_frames_r) > 32'(MAX_FRAMES)) begin
      n_clamp = CNT_W'(MAX_FRAMES);
    end else begin
      n_clamp = CNT_W'(active_frames_r);
    end
  end

  // walk control: read frame cnt, process frame cnt-1 from the read register
  assign rd_en    = cmd.walk && (cnt_r < n_r);
  assign proc_en  = cmd.walk && (cnt_r != '0);
  assign proc_idx = IDX_W'(cnt_r - CNT_W'(1));
  assign aged     = rd_valid_r ? (rd_age_r >> 1) : '0;
  assign status.walk_last = (cnt_r == n_r);

  // slot choice: match, else first empty, else least age
  assign evict_now = !match_found_r && !empty_found_r;
  always_comb begin
    if (match_found_r) begin
      slot = match_idx_r;
    end else if (empty_found_r) begin
      slot = empty_idx_r;
    end else begin
      slot = old_idx_r;
    end
  end

  // single write port: aged write-back during walk, slot write on update
  assign wr_en   = proc_en || cmd.update;
  assign wr_addr = cmd.update ? slot : proc_idx;
  always_comb begin
    if (cmd.update) begin
      wr_data = {page_r, (match_found_r ? (match_age_r | AGE_TOP) : AGE_TOP)};
    end else begin
      wr_data = {rd_page_r, aged};
    end
  end

  // frame table memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      {rd_page_r, rd_age_r} <= frame_mem_r[cnt_r[IDX_W-1:0]];
      rd_valid_r            <= frame_valid_r[cnt_r[IDX_W-1:0]];
    end
  end

  // saturating totals
  assign hit_total_nxt  = (match_found_r && !(&hit_total_r)) ? hit_total_r + COUNT_W'(1)
                                                              : hit_total_r;
  assign miss_total_nxt = (!match_found_r && !(&miss_total_r)) ? miss_total_r + COUNT_W'(1)
                                                                : miss_total_r;

  // control state: config, valid bits, counters, search flags, strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_frames_r <= CFG_RESET;
      frame_valid_r   <= '0;
      hit_total_r     <= '0;
      miss_total_r    <= '0;
      cnt_r           <= '0;
      match_found_r   <= 1'b0;
      empty_found_r   <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
      if (cfg_wr_en) begin
        active_frames_r <= cfg_active_frames;
      end
      if (cmd.load) begin
        cnt_r         <= '0;
        match_found_r <= 1'b0;
        empty_found_r <= 1'b0;
      end
      if (cmd.walk) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (proc_en) begin
        if (!match_found_r && rd_valid_r && (rd_page_r == page_r)) begin
          match_found_r <= 1'b1;
        end
        if (!empty_found_r && !rd_valid_r) begin
          empty_found_r <= 1'b1;
        end
      end
      if (cmd.update) begin
        frame_valid_r[slot] <= 1'b1;
        hit_total_r         <= hit_total_nxt;
        miss_total_r        <= miss_total_nxt;
      end
    end
  end

  // payload: request word, search results, result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= in_page_number;
      n_r    <= n_clamp;
    end
    if (proc_en) begin
      if (!match_found_r && rd_valid_r && (rd_page_r == page_r)) begin
        match_idx_r <= proc_idx;
        match_age_r <= aged;
      end
      if (!empty_found_r && !rd_valid_r) begin
        empty_idx_r <= proc_idx;
      end
      if ((proc_idx == '0) || (aged < min_age_r)) begin
        min_age_r  <= aged;
        old_idx_r  <= proc_idx;
        old_page_r <= rd_page_r;
      end
    end
    if (cmd.update) begin
      out_hit_r           <= match_found_r;
      out_frame_index_r   <= slot;
      out_evicted_valid_r <= evict_now;
      out_evicted_page_r  <= evict_now ? old_page_r : '0;
      out_hits_r          <= hit_total_nxt;
      out_misses_r        <= miss_total_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_frame_index_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_hits_so_far   = out_hits_r;
  assign out_misses_so_far = out_misses_r;

endmodule

[sv/aging_page_replacement_unit.sv]
// top level of the aging page replacement unit: controller plus datapath
// sequence: accept loads the word, the walk ages the N active frames (N the active frame count)
//   one frame per cycle through the single read port of the frame table, the update state
//   writes the slot, then the result strobe is registered; no new word is taken until idle
// reset: frame table empty (empty frames age as zero), hit and miss totals zero, frame count 10
// results are shown for one cycle only; the receiver cannot stall
`timescale 1ns / 1ps

module aging_page_replacement_unit import apru_pkg::*; #(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int AGE_BITS   = DEF_AGE_BITS,
  localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_active_frames,
  output logic               out_valid,
  output logic               out_hit,
  output logic [IDX_W-1:0]   out_frame_index,
  output logic               out_evicted_valid,
  output logic [PAGE_W-1:0]  out_evicted_page,
  output logic [COUNT_W-1:0] out_hits_so_far,
  output logic [COUNT_W-1:0] out_misses_so_far
);

  cmd_t    cmd;
  status_t status;

  // sequencing
  apru_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // frame table and search
  apru_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .AGE_BITS   (AGE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_page_number    (in_page_number),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_active_frames (cfg_active_frames),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hits_so_far   (out_hits_so_far),
    .out_misses_so_far (out_misses_so_far)
  );

endmodule

[sv/apru_checker.sv]
// port-level checker for the aging page replacement unit, bound to the top level
`timescale 1ns / 1ps

module apru_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_hit,
  input logic        out_evicted_valid,
  input logic [15:0] out_evicted_page
);

  // an accepted word makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // a result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // the result appears only once the unit has gone idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_evicted_valid)
    else $error("eviction reported on a hit");

  // evicted page reads zero when nothing was evicted
  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted_valid) |-> (out_evicted_page == 16'd0))
    else $error("evicted page not zero without eviction");

endmodule

bind aging_page_replacement_unit apru_checker u_apru_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_hit           (out_hit),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_page  (out_evicted_page)
);

[tb/apru_checker.sv]
// checker for the aging page replacement unit: frame table predictor and result comparison
`timescale 1ns / 1ps

module apru_tb_checker import apru_pkg::*; (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [PAGE_W-1:0]                   in_page_number,
  input  logic                                cfg_wr_en,
  input  logic [CFG_W-1:0]                    cfg_active_frames,
  input  logic                                out_valid,
  input  logic                                out_hit,
  input  logic [$clog2(DEF_MAX_FRAMES)-1:0]   out_frame_index,
  input  logic                                out_evicted_valid,
  input  logic [PAGE_W-1:0]                   out_evicted_page,
  input  logic [COUNT_W-1:0]                  out_hits_so_far,
  input  logic [COUNT_W-1:0]                  out_misses_so_far,
  output int                                  mismatch_count,
  output int                                  words_due
);

  localparam int FRAMES = DEF_MAX_FRAMES;
  localparam int AGE_W  = DEF_AGE_BITS;
  localparam int IDX_W  = $clog2(DEF_MAX_FRAMES);

  // one predicted result word
  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   frame;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] misses;
  } placement_t;

  // predictor's own copy of the frame table and totals
  logic [PAGE_W-1:0]  page_tab [FRAMES];
  logic               vld_tab  [FRAMES];
  logic [AGE_W-1:0]   age_tab  [FRAMES];
  logic [COUNT_W-1:0] hit_total;
  logic [COUNT_W-1:0] miss_total;
  logic [CFG_W-1:0]   frames_reg;

  placement_t due_placements[$];
  placement_t want;
  int         words_seen;

  // age every active frame, then look the page up or place it
  function automatic placement_t age_and_place(input logic [PAGE_W-1:0] page);
    int         n;
    int         match;
    int         empty;
    int         oldest;
    int         slot;
    placement_t p;
    p      = '0;
    match  = -1;
    empty  = -1;
    oldest = 0;
    // out-of-range counts clamp to 1..FRAMES
    if (frames_reg == 0) n = 1;
    else if (frames_reg > FRAMES) n = FRAMES;
    else n = frames_reg;
    for (int i = 0; i < n; i++) begin
      age_tab[i] = age_tab[i] >> 1;
      if (vld_tab[i]) begin
        if (match < 0 && page_tab[i] == page) match = i;
      end else if (empty < 0) begin
        empty = i;
      end
      if (age_tab[i] < age_tab[oldest]) oldest = i;
    end
    if (match >= 0) begin
      slot = match;
      age_tab[slot][AGE_W-1] = 1'b1;
      p.hit = 1'b1;
      if (hit_total != '1) hit_total = hit_total + 1;
    end else begin
      if (empty >= 0) begin
        slot = empty;
      end else begin
        // lowest index wins a tie on age
        slot       = oldest;
        p.ev_valid = 1'b1;
        p.ev_page  = page_tab[slot];
      end
      page_tab[slot] = page;
      vld_tab[slot]  = 1'b1;
      age_tab[slot]  = '0;
      age_tab[slot][AGE_W-1] = 1'b1;
      if (miss_total != '1) miss_total = miss_total + 1;
    end
    p.frame  = slot[IDX_W-1:0];
    p.hits   = hit_total;
    p.misses = miss_total;
    return p;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAMES; i++) begin
        page_tab[i] = '0;
        vld_tab[i]  = 1'b0;
        age_tab[i]  = '0;
      end
      hit_total  = '0;
      miss_total = '0;
      frames_reg = CFG_RESET;
      due_placements.delete();
      mismatch_count = 0;
      words_seen     = 0;
      words_due <= 0;
    end else begin
      // compare a result word with the oldest prediction
      if (out_valid) begin
        if (due_placements.size() == 0) begin
          report_mismatch($sformatf("result word %0d with nothing due", words_seen));
        end else begin
          want = due_placements.pop_front();
          if (out_hit !== want.hit)
            report_mismatch($sformatf("word %0d hit got %0b want %0b",
                                      words_seen, out_hit, want.hit));
          if (out_frame_index !== want.frame)
            report_mismatch($sformatf("word %0d frame_index got %0d want %0d",
                                      words_seen, out_frame_index, want.frame));
          if (out_evicted_valid !== want.ev_valid)
            report_mismatch($sformatf("word %0d evicted_valid got %0b want %0b",
                                      words_seen, out_evicted_valid, want.ev_valid));
          if (out_evicted_page !== want.ev_page)
            report_mismatch($sformatf("word %0d evicted_page got %h want %h",
                                      words_seen, out_evicted_page, want.ev_page));
          if (out_hits_so_far !== want.hits)
            report_mismatch($sformatf("word %0d hits_so_far got %0d want %0d",
                                      words_seen, out_hits_so_far, want.hits));
          if (out_misses_so_far !== want.misses)
            report_mismatch($sformatf("word %0d misses_so_far got %0d want %0d",
                                      words_seen, out_misses_so_far, want.misses));
        end
        words_seen++;
      end
      // register write
      if (cfg_wr_en) frames_reg = cfg_active_frames;
      // accepted reference word
      if (start && !busy) due_placements.push_back(age_and_place(in_page_number));
      words_due <= due_placements.size();
    end
  end

endmodule

[tb/tb_aging_page_replacement_unit.sv]
// testbench top for the aging page replacement unit: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module tb_aging_page_replacement_unit;
  import apru_pkg::*;

  localparam int IDX_W       = $clog2(DEF_MAX_FRAMES);
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 64;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [PAGE_W-1:0]  in_page_number = '0;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]   cfg_active_frames = '0;
  logic               busy;
  logic               out_valid;
  logic               out_hit;
  logic [IDX_W-1:0]   out_frame_index;
  logic               out_evicted_valid;
  logic [PAGE_W-1:0]  out_evicted_page;
  logic [COUNT_W-1:0] out_hits_so_far;
  logic [COUNT_W-1:0] out_misses_so_far;
  int                 mismatch_count;
  int                 words_due;
  int                 cycle_count = 0;

  // frame counts for the random phases, clamped values among them
  int unsigned phase_frames [11] = '{16, 5, 31, 1, 8, 17, 3, 12, 2, 7, 16};

  aging_page_replacement_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_active_frames (cfg_active_frames),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hits_so_far   (out_hits_so_far),
    .out_misses_so_far (out_misses_so_far)
  );

  apru_tb_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_active_frames (cfg_active_frames),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hits_so_far   (out_hits_so_far),
    .out_misses_so_far (out_misses_so_far),
    .mismatch_count    (mismatch_count),
    .words_due         (words_due)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** aging_page_replacement_unit: FAILED **");
      $finish;
    end
  end

  // offer one reference word and hold it until taken
  task automatic send_page(input logic [PAGE_W-1:0] page);
    start          <= 1'b1;
    in_page_number <= page;
    do @(posedge clk); while (busy);
  endtask

  // drop start for a number of cycles
  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // wait until every predicted word has come back and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (words_due != 0 || busy) @(posedge clk);
  endtask

  // write the frame count with the block idle
  task automatic set_frames(input logic [CFG_W-1:0] count);
    drain();
    cfg_wr_en         <= 1'b1;
    cfg_active_frames <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [PAGE_W-1:0] base;
    int unsigned       span;
    bit                no_gaps;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset frame count: page extremes, a hit, fresh frames
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'hAAAA);
    send_page(16'h5555);

    // a count of zero behaves as one frame, so frame 0 is always the victim
    set_frames(5'd0);
    send_page(16'hFFFF);
    send_page(16'h0001);
    send_page(16'hFFFF);
    send_page(16'hFFFF);

    // grow past the table: frames 0 and 1 both hold the same page, lowest wins
    set_frames(5'd31);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'h1234);

    // two frames: victim by smallest age
    set_frames(5'd2);
    send_page(16'h1111);
    send_page(16'h2222);
    send_page(16'h1111);
    send_page(16'h3333);
    send_page(16'h2222);

    // random phases over a spread of frame counts
    foreach (phase_frames[ph]) begin
      set_frames(phase_frames[ph][CFG_W-1:0]);
      base    = PAGE_W'($urandom);
      span    = $urandom_range(2, 40);
      no_gaps = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // mostly a small working set, sometimes any page at all
        if ($urandom_range(0, 99) < 85)
          send_page(base + PAGE_W'($urandom_range(0, span - 1)));
        else
          send_page(PAGE_W'($urandom));
        if ($urandom_range(0, 29) == 0) drain();
        else if (!no_gaps) idle_for(gap_len());
      end
    end

    // let the last words come back
    drain();
    repeat (25) @(posedge clk);
    if (mismatch_count == 0)
      $display("** aging_page_replacement_unit: PASSED **");
    else
      $display("** aging_page_replacement_unit: FAILED **");
    $finish;
  end

endmodule
